/* rtl/rtp_pkg.sv */
// Shared types, constants and the character decode for the radix text parser.
package rtp_pkg;

  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [6:0] NOT_A_DIGIT = 7'd99;
  localparam logic [5:0] MIN_BASE    = 6'd2;
  localparam logic [5:0] MAX_BASE    = 6'd36;

  localparam logic [5:0] BASE_RESET  = 6'd10;
  localparam logic       SIGNED_RESET = 1'b1;
  localparam logic [1:0] WIDTH_RESET = 2'd2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_NUMBER_BASE  = 2'd0,
    REG_SIGNED_MODE  = 2'd1,
    REG_WIDTH_SELECT = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    WSEL_8  = 2'd0,
    WSEL_16 = 2'd1,
    WSEL_32 = 2'd2,
    WSEL_64 = 2'd3
  } width_sel_t;

  typedef struct packed {
    logic [5:0] number_base;
    logic       signed_mode;
    logic [1:0] width_select;
  } cfg_t;

  typedef struct packed {
    logic [63:0] magnitude;
    logic        overflowed;
    logic        is_negative;
    logic        seen_digit;
    logic        field_ended;
  } parse_state_t;

  function automatic logic [6:0] digit_value(input logic [7:0] ch);
    logic [7:0] d;
    d = {1'b0, NOT_A_DIGIT};
    if (ch inside {[CH_ZERO:CH_NINE]}) begin
      d = ch - CH_ZERO;
    end else if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      d = ch - CH_LOWER_A + 8'd10;
    end else if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      d = ch - CH_UPPER_A + 8'd10;
    end
    return d[6:0];
  endfunction

  // Full-width mask of the selected result width
  function automatic logic [63:0] width_mask(input logic [1:0] wsel);
    logic [63:0] m;
    case (wsel)
      WSEL_8:  m = 64'h0000_0000_0000_00FF;
      WSEL_16: m = 64'h0000_0000_0000_FFFF;
      WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
      WSEL_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* rtl/rtp_step.sv */
// One character step of the parse: sign, digit decode, multiply-accumulate and range check.
module rtp_step (
  input  logic [7:0]            character,
  input  logic                  count_zero,
  input  rtp_pkg::cfg_t         cfg,
  input  rtp_pkg::parse_state_t state,
  output rtp_pkg::parse_state_t state_nxt,
  output logic                  count_up
);

  logic [6:0]  digit;
  logic        base_ok;
  logic        at_start;
  logic        take_minus;
  logic        take_digit;
  logic [63:0] half;
  logic [63:0] limit;
  logic [69:0] product;

  assign digit    = rtp_pkg::digit_value(character);
  assign base_ok  = (cfg.number_base >= rtp_pkg::MIN_BASE) &&
                    (cfg.number_base <= rtp_pkg::MAX_BASE);
  assign at_start = count_zero && !state.is_negative && !state.seen_digit;

  assign take_minus = at_start && cfg.signed_mode && (character == rtp_pkg::CH_MINUS);
  assign take_digit = base_ok && (digit < {1'b0, cfg.number_base});

  // Largest magnitude the selected range can hold
  always_comb begin
    half = (rtp_pkg::width_mask(cfg.width_select) >> 1) + 64'd1;
    if (cfg.signed_mode) begin
      limit = state.is_negative ? half : half - 64'd1;
    end else begin
      limit = rtp_pkg::width_mask(cfg.width_select);
    end
  end

  // m*b + d > limit is the same test as m > (limit - d) / b
  assign product = 70'(state.magnitude) * 70'(cfg.number_base) + 70'(digit);

  always_comb begin
    state_nxt = state;
    count_up  = 1'b0;
    if (!state.field_ended) begin
      if (take_minus) begin
        state_nxt.is_negative = 1'b1;
        count_up              = 1'b1;
      end else if (take_digit) begin
        state_nxt.seen_digit = 1'b1;
        count_up             = 1'b1;
        if (!state.overflowed) begin
          if (product > {6'd0, limit}) begin
            state_nxt.overflowed = 1'b1;
          end else begin
            state_nxt.magnitude = product[63:0];
          end
        end
      end else begin
        state_nxt.field_ended = 1'b1;
      end
    end
  end

endmodule

/* rtl/radix_integer_text_parser.sv */
// Top level of the streaming radix 2..36 integer text parser.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_character[7:0], in_last
//  out     | output    | out_valid/out_stall | out_value[63:0], out_status[1:0],
//          |           |                     | out_consumed_chars[15:0]
//  cfg     | input     | cfg_wr_en           | cfg_index[1:0], cfg_data[5:0]
//
// One character per cycle while in_stall is low; a buffer's result is registered in the
// output register as its last character leaves the input register. The per-character
// multiply-accumulate (64 x 6 bits) and range compare sit in one stage between the two.
// Reset (synchronous, rst_n low) loads the default configuration and clears parse state.
// A stalled result holds in the output register while other characters keep flowing;
// input stalls only while a last character waits in the input register behind it.
module radix_integer_text_parser #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_last,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic [1:0]  out_status,
  output logic [15:0] out_consumed_chars,

  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  rtp_pkg::cfg_t         cfg_r;
  rtp_pkg::parse_state_t state_r;
  rtp_pkg::parse_state_t step_state;
  rtp_pkg::parse_state_t state_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_step;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  count_up;

  logic                  in_valid_r;
  logic [7:0]            in_character_r;
  logic                  in_last_r;
  logic                  advance;
  logic                  in_take;

  logic                  out_valid_r;
  logic [63:0]           out_value_r;
  logic [1:0]            out_status_r;
  logic [15:0]           out_consumed_r;
  logic [63:0]           value_nxt;
  logic [1:0]            status_nxt;
  logic [15:0]           consumed_nxt;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.number_base  <= rtp_pkg::BASE_RESET;
      cfg_r.signed_mode  <= rtp_pkg::SIGNED_RESET;
      cfg_r.width_select <= rtp_pkg::WIDTH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rtp_pkg::REG_NUMBER_BASE:  cfg_r.number_base  <= cfg_data;
        rtp_pkg::REG_SIGNED_MODE:  cfg_r.signed_mode  <= cfg_data[0];
        rtp_pkg::REG_WIDTH_SELECT: cfg_r.width_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // A character without last never needs the output register
  assign advance  = in_valid_r && (!in_last_r || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_character_r <= in_character;
      in_last_r      <= in_last;
    end
  end

  rtp_step u_step (
    .character  (in_character_r),
    .count_zero (count_r == '0),
    .cfg        (cfg_r),
    .state      (state_r),
    .state_nxt  (step_state),
    .count_up   (count_up)
  );

  // Saturate the consumed count
  assign count_step = (count_up && (count_r != '1)) ? count_r + 1'b1 : count_r;

  always_comb begin
    value_nxt    = '0;
    consumed_nxt = '0;
    if (!step_state.seen_digit) begin
      status_nxt = rtp_pkg::ST_INVALID;
    end else if (step_state.overflowed) begin
      status_nxt   = rtp_pkg::ST_RANGE;
      consumed_nxt = 16'(count_step);
    end else begin
      status_nxt   = rtp_pkg::ST_OK;
      consumed_nxt = 16'(count_step);
      value_nxt    = (step_state.is_negative ? (64'd0 - step_state.magnitude)
                                             : step_state.magnitude)
                     & rtp_pkg::width_mask(cfg_r.width_select);
    end
  end

  // Advance the parse on each character that moves on, and clear it after the last character of a buffer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    if (advance) begin
      if (in_last_r) begin
        state_nxt = '0;
        count_nxt = '0;
      end else begin
        state_nxt = step_state;
        count_nxt = count_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_value_r    <= value_nxt;
      out_status_r   <= status_nxt;
      out_consumed_r <= consumed_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_status         = out_status_r;
  assign out_consumed_chars = out_consumed_r;

  // An invalid argument carries neither value nor count
  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == rtp_pkg::ST_INVALID))
      |-> (out_value_r == '0) && (out_consumed_r == '0))
    else $error("invalid result with nonzero value or count");

  a_range_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == rtp_pkg::ST_RANGE)) |-> (out_value_r == '0))
    else $error("out-of-range result with nonzero value");

  // Once the field has ended it stays ended until the buffer closes
  a_field_end_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.field_ended && !(advance && in_last_r)) |=> state_r.field_ended)
    else $error("field end dropped inside a buffer");

  a_no_digit_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.overflowed |-> state_r.seen_digit)
    else $error("overflow without a digit");

endmodule
